FILE: src/pixel_tone_adjust_macros.svh
// Assertion macros for the pixel tone adjust block.
// Used by the checker; expects aclk and aresetn in scope.
`ifndef PIXEL_TONE_ADJUST_MACROS_SVH
`define PIXEL_TONE_ADJUST_MACROS_SVH

// property sampled on aclk, held off while in reset
`define PTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property sampled on aclk, also checked through reset
`define PTA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/pta_pkg.sv
// Shared types, constants and elaboration-time functions for pixel_tone_adjust.
// No dependencies.
`default_nettype none

package pta_pkg;

    localparam int CHAN_W    = 16;
    localparam int OUT_W     = 13;
    localparam int GAIN_W    = 17;
    localparam int CFG_IDX_W = 4;
    localparam int LOG_BITS  = 24;
    localparam int MANT_BITS = 30;

    localparam logic [10:0] LUMA_WR = 11'd871;
    localparam logic [11:0] LUMA_WG = 12'd2929;
    localparam logic [8:0]  LUMA_WB = 9'd296;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA      = 4'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } pta_pix_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] out_red;
        logic [OUT_W-1:0] out_green;
        logic [OUT_W-1:0] out_blue;
    } pta_pix_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0] brightness_gain;
        logic [GAIN_W-1:0] saturation_gain;
        logic [GAIN_W-1:0] contrast_gain;
        logic [GAIN_W-1:0] gamma_exponent;
    } pta_gains_t;

    typedef enum logic [1:0] {
        PW_NORMAL,
        PW_ONE,
        PW_ZERO
    } pta_pw_code_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q30, by repeated truncated square roots
    function automatic logic [MANT_BITS:0] exp_root(input int k);
        logic [63:0] root;
        root = 64'd1 << (MANT_BITS + 1);
        for (int i = 1; i <= k; i++) begin
            root = isqrt64(root << MANT_BITS);
        end
        return root[MANT_BITS:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/pixel_tone_adjust.sv
// Pixel tone adjust: luma and configuration registers, three channel pipelines.
// Depends on pta_pkg and pta_channel.
`default_nettype none

// Takes one RGB pixel per clock unless held, and returns it after saturation, brightness,
// contrast and gamma; most of the pipeline is the 24-step log2 and 24-step exp2 chains, one
// multiplier per stage. The whole pipeline holds while a result waits and m_ready is low.
// Write the four gain registers through the cfg port only while no pixel is in flight.

module pixel_tone_adjust
    import pta_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pta_pix_in_t          s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pta_pix_out_t              m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    localparam int PIPE_LAT = 57;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(2 ** FRAC_BITS);

    pta_gains_t gains_reg;
    logic       adv;
    logic [PIPE_LAT-1:0] valid_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !valid_reg[PIPE_LAT-1] || m_ready;
    assign s_ready   = adv;
    assign m_valid   = valid_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.brightness_gain <= GAIN_ONE;
            gains_reg.saturation_gain <= GAIN_ONE;
            gains_reg.contrast_gain   <= GAIN_ONE;
            gains_reg.gamma_exponent  <= GAIN_ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BRIGHTNESS: gains_reg.brightness_gain <= {1'b0, cfg_data};
                REG_SATURATION: gains_reg.saturation_gain <= {1'b0, cfg_data};
                REG_CONTRAST:   gains_reg.contrast_gain   <= {1'b0, cfg_data};
                REG_GAMMA:      gains_reg.gamma_exponent  <= {1'b0, cfg_data};
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    logic [28:0]       luma_sum;
    logic [CHAN_W-1:0] luma_reg;
    pta_pix_in_t       pix_reg;

    assign luma_sum = 29'(s_data.in_red) * 29'(LUMA_WR)
                    + 29'(s_data.in_green) * 29'(LUMA_WG)
                    + 29'(s_data.in_blue) * 29'(LUMA_WB)
                    + 29'd2048;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix_reg  <= s_data;
            luma_reg <= luma_sum[27:12];
        end
    end

    pta_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
        .aclk     (aclk),
        .adv      (adv),
        .gains    (gains_reg),
        .chan_in  (pix_reg.in_red),
        .luma_in  (luma_reg),
        .chan_out (m_data.out_red)
    );

    pta_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
        .aclk     (aclk),
        .adv      (adv),
        .gains    (gains_reg),
        .chan_in  (pix_reg.in_green),
        .luma_in  (luma_reg),
        .chan_out (m_data.out_green)
    );

    pta_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .aclk     (aclk),
        .adv      (adv),
        .gains    (gains_reg),
        .chan_in  (pix_reg.in_blue),
        .luma_in  (luma_reg),
        .chan_out (m_data.out_blue)
    );

endmodule

`default_nettype wire

FILE: src/pta_channel.sv
// One colour channel of pixel_tone_adjust: gains, clamp, log2, power, exp2.
// 56 register stages; depends on pta_pkg.
`default_nettype none

module pta_channel
    import pta_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic              aclk,
    input  wire logic              adv,
    input  wire pta_gains_t        gains,
    input  wire logic [CHAN_W-1:0] chan_in,
    input  wire logic [CHAN_W-1:0] luma_in,
    output logic [OUT_W-1:0]       chan_out
);

    localparam int WP1 = 17 + GAIN_W + 1;
    localparam int WV1 = WP1 + 2 - FRAC_BITS;
    localparam int WP2 = WV1 + GAIN_W + 1;
    localparam int WV2 = WP2 + 2 - FRAC_BITS;
    localparam int WP3 = WV2 + 1 + GAIN_W + 1;
    localparam int WV3 = WP3 + 2 - FRAC_BITS;
    localparam int MW  = MANT_BITS + 1;
    localparam int LW  = 30;
    localparam int PGW = LW + GAIN_W + 1;
    localparam int TW  = PGW + 1;

    localparam logic signed [WP1:0]   RND1  = (WP1 + 1)'(2 ** (FRAC_BITS - 1));
    localparam logic signed [WP2:0]   RND2  = (WP2 + 1)'(2 ** (FRAC_BITS - 1));
    localparam logic signed [WP3:0]   RND3  = (WP3 + 1)'(2 ** (FRAC_BITS - 1));
    localparam logic signed [TW-1:0]  RNDG  = TW'(2 ** (FRAC_BITS - 1));
    localparam logic signed [WV2:0]   HALF2 = (WV2 + 1)'(2 ** (FRAC_BITS - 1));
    localparam logic signed [WV3-1:0] HALF3 = WV3'(2 ** (FRAC_BITS - 1));
    localparam logic signed [WV3-1:0] ONE3  = WV3'(2 ** FRAC_BITS);
    localparam logic [MW-1:0]         ACC_INIT = MW'(2 ** MANT_BITS);
    localparam logic [31:0]           ONE32 = 32'(2 ** FRAC_BITS);
    localparam logic [16:0]           ONE17 = 17'(2 ** FRAC_BITS);

    // saturation
    logic signed [16:0]    d_a;
    logic signed [WP1-1:0] p_a;
    logic signed [WP1:0]   r_a;
    logic signed [WV1-1:0] v1_next;
    logic signed [WV1-1:0] v1_reg;

    always_comb begin
        d_a     = $signed({1'b0, chan_in}) - $signed({1'b0, luma_in});
        p_a     = d_a * $signed({1'b0, gains.saturation_gain});
        r_a     = $signed({p_a[WP1-1], p_a}) + RND1;
        v1_next = WV1'(r_a >>> FRAC_BITS) + WV1'($signed({1'b0, luma_in}));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v1_reg <= v1_next;
        end
    end

    // brightness
    logic signed [WP2-1:0] p_b;
    logic signed [WP2:0]   r_b;
    logic signed [WV2-1:0] v2_reg;

    always_comb begin
        p_b = v1_reg * $signed({1'b0, gains.brightness_gain});
        r_b = $signed({p_b[WP2-1], p_b}) + RND2;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v2_reg <= WV2'(r_b >>> FRAC_BITS);
        end
    end

    // contrast product
    logic signed [WV2:0]   d_c;
    logic signed [WP3-1:0] p_c_reg;

    assign d_c = $signed({v2_reg[WV2-1], v2_reg}) - HALF2;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_c_reg <= d_c * $signed({1'b0, gains.contrast_gain});
        end
    end

    // contrast rounding, clamp and special cases
    logic signed [WP3:0]   r_d;
    logic signed [WV3-1:0] v3;
    pta_pw_code_t          code_d_next;
    pta_pw_code_t          code_d_reg;
    logic [FRAC_BITS-1:0]  x_d_reg;

    always_comb begin
        r_d = $signed({p_c_reg[WP3-1], p_c_reg}) + RND3;
        v3  = WV3'(r_d >>> FRAC_BITS) + HALF3;
        if (gains.gamma_exponent == '0 || v3 >= ONE3) begin
            code_d_next = PW_ONE;
        end else if (v3[WV3-1] || v3 == '0) begin
            code_d_next = PW_ZERO;
        end else begin
            code_d_next = PW_NORMAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            code_d_reg <= code_d_next;
            x_d_reg    <= v3[FRAC_BITS-1:0];
        end
    end

    // normalise to a Q30 mantissa
    logic [4:0]            msb_e;
    logic [MW-1:0]         m_l    [0:LOG_BITS];
    logic [LOG_BITS-1:0]   frac_l [0:LOG_BITS];
    logic [4:0]            n_l    [0:LOG_BITS];
    pta_pw_code_t          code_l [0:LOG_BITS];

    always_comb begin
        msb_e = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (x_d_reg[i]) begin
                msb_e = 5'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_l[0]    <= MW'(x_d_reg) << (5'd30 - msb_e);
            frac_l[0] <= '0;
            n_l[0]    <= 5'(FRAC_BITS) - msb_e;
            code_l[0] <= code_d_reg;
        end
    end

    // log2 fraction, one bit per stage
    for (genvar k = 0; k < LOG_BITS; k++) begin : g_log
        logic [2*MW-1:0] sq;
        logic [31:0]     sh;

        always_comb begin
            sq = m_l[k] * m_l[k];
            sh = sq[MANT_BITS +: 32];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                m_l[k+1]    <= sh[31] ? sh[31:1] : sh[30:0];
                frac_l[k+1] <= {frac_l[k][LOG_BITS-2:0], sh[31]};
                n_l[k+1]    <= n_l[k];
                code_l[k+1] <= code_l[k];
            end
        end
    end

    // scale log by exponent
    logic signed [LW-1:0]  lg_g;
    logic signed [PGW-1:0] prod_g_reg;
    pta_pw_code_t          code_g_reg;

    assign lg_g = $signed({6'b0, frac_l[LOG_BITS]})
                - $signed({1'b0, n_l[LOG_BITS], 24'b0});

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_g_reg <= lg_g * $signed({1'b0, gains.gamma_exponent});
            code_g_reg <= code_l[LOG_BITS];
        end
    end

    // split into integer and fraction parts
    logic signed [TW-1:0] t_h;
    logic signed [TW-1:0] t_hc;
    logic signed [TW-1:0] e_wide;
    pta_pw_code_t         code_h_next;

    always_comb begin
        t_h = ($signed({prod_g_reg[PGW-1], prod_g_reg}) + RNDG) >>> FRAC_BITS;
        if (!t_h[TW-1] && t_h != '0) begin
            t_hc = '0;
        end else begin
            t_hc = t_h;
        end
        e_wide      = -(t_hc >>> LOG_BITS);
        code_h_next = code_g_reg;
        if (code_g_reg == PW_NORMAL && e_wide > TW'(FRAC_BITS + 1)) begin
            code_h_next = PW_ZERO;
        end
    end

    logic [MW-1:0]       acc_x  [1:LOG_BITS];
    logic [LOG_BITS-1:0] f_x    [0:LOG_BITS];
    logic [4:0]          e_x    [0:LOG_BITS];
    pta_pw_code_t        code_x [0:LOG_BITS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_x[0]    <= t_hc[LOG_BITS-1:0];
            e_x[0]    <= e_wide[4:0];
            code_x[0] <= code_h_next;
        end
    end

    // exp2 of the fraction, one root per stage
    for (genvar k = 1; k <= LOG_BITS; k++) begin : g_exp
        localparam logic [MW-1:0] ROOT_K = exp_root(k);
        logic [MW-1:0]   acc_prev;
        logic [2*MW-1:0] prod;

        if (k == 1) begin : g_first
            assign acc_prev = ACC_INIT;
        end else begin : g_rest
            assign acc_prev = acc_x[k-1];
        end

        assign prod = acc_prev * ROOT_K;

        always_ff @(posedge aclk) begin
            if (adv) begin
                acc_x[k]  <= f_x[k-1][LOG_BITS-k] ? prod[MANT_BITS +: MW] : acc_prev;
                f_x[k]    <= f_x[k-1];
                e_x[k]    <= e_x[k-1];
                code_x[k] <= code_x[k-1];
            end
        end
    end

    // integer part shift with rounding, final clamp
    logic [5:0]       s_z;
    logic [31:0]      sum_z;
    logic [31:0]      y_z;
    logic [16:0]      res_z;
    logic [OUT_W-1:0] chan_out_reg;

    always_comb begin
        s_z   = 6'(MANT_BITS - FRAC_BITS) + 6'(e_x[LOG_BITS]);
        sum_z = 32'(acc_x[LOG_BITS]) + (32'd1 << (s_z - 6'd1));
        y_z   = sum_z >> s_z;
        case (code_x[LOG_BITS])
            PW_ONE:    res_z = ONE17;
            PW_ZERO:   res_z = '0;
            PW_NORMAL: res_z = (y_z > ONE32) ? ONE17 : y_z[16:0];
            default:   res_z = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            chan_out_reg <= res_z[OUT_W-1:0];
        end
    end

    assign chan_out = chan_out_reg;

endmodule

`default_nettype wire

FILE: src/pta_checker.sv
// Port-level checks on pixel_tone_adjust, attached by bind.
// Depends on pta_pkg and pixel_tone_adjust_macros.svh.
`default_nettype none
`include "pixel_tone_adjust_macros.svh"

module pta_checker
    import pta_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire pta_pix_in_t          s_data,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire pta_pix_out_t         m_data,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready
);

    `PTA_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat dropped or changed while stalled")
    `PTA_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid && $stable(s_data), "input beat dropped or changed while waiting")
    `PTA_ASSERT(a_flow, !m_valid || m_ready |-> s_ready, "input held back with no result waiting")
    `PTA_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration beat held back")
    `PTA_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result shown straight after reset")

endmodule

bind pixel_tone_adjust pta_checker u_pta_checker (.*);

`default_nettype wire
